### hw/rtl/cdf_lower_bound_search_top_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the cumulative-weight search block
// Concurrent checks clocked on clk_i and disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef CDF_LOWER_BOUND_SEARCH_TOP_ASSERT_SVH
`define CDF_LOWER_BOUND_SEARCH_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CDFLS_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CDFLS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hw/rtl/cdfls_pkg.sv
// ----------------------------------------------------------------------------
// Cumulative-weight search package
// Shared widths, codes, state encoding and controller/datapath bundles.
// ----------------------------------------------------------------------------
package cdfls_pkg;

  localparam int unsigned DEF_TABLE_DEPTH = 1024;
  localparam int unsigned DEF_VALUE_BITS  = 32;

  localparam int unsigned IDX_W       = 11;
  localparam int unsigned ENTRY_IDX_W = 10;
  localparam int unsigned FIELD_VAL_W = 32;

  localparam logic [IDX_W-1:0] COUNT_RESET = 11'd1024;

  typedef enum logic {
    OP_LOAD  = 1'b0,
    OP_QUERY = 1'b1
  } opcode_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FIRST,
    ST_PROBE
  } state_e;

  typedef struct packed {
    logic load;
    logic launch;
    logic first;
    logic probe;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic done;
  } status_t;

endpackage

### hw/rtl/cdf_lower_bound_search_top.sv
// ----------------------------------------------------------------------------
// Cumulative-weight lower-bound search
// A query is a launch step, a first step and then the table probes; each
// probe reads two neighboring entries through the two table read ports.
// The result strobe rises in the cycle after the search decides; the receiver
// cannot stall. Reset sets the entry count to 1024; table contents are kept.
// ----------------------------------------------------------------------------
module cdf_lower_bound_search_top import cdfls_pkg::*; #(
  parameter int unsigned TABLE_DEPTH = DEF_TABLE_DEPTH,
  parameter int unsigned VALUE_BITS  = DEF_VALUE_BITS
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  output logic                   busy_o,
  input  logic                   opcode_i,
  input  logic [ENTRY_IDX_W-1:0] entry_index_i,
  input  logic [FIELD_VAL_W-1:0] entry_value_i,
  input  logic [FIELD_VAL_W-1:0] search_value_i,
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [IDX_W-1:0]       cfg_data_i,
  output logic                   done_o,
  output logic [IDX_W-1:0]       found_index_o,
  output logic                   beyond_end_o
);

  cmd_t    cmd;
  status_t status;

  assign cfg_ready_o = ~busy_o;

  cdfls_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start_i),
    .opcode_i (opcode_i),
    .status_i (status),
    .busy_o   (busy_o),
    .cmd_o    (cmd)
  );

  cdfls_dpath #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .VALUE_BITS  (VALUE_BITS)
  ) u_dpath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .status_o       (status),
    .cfg_we_i       (cfg_valid_i & cfg_ready_o),
    .cfg_data_i     (cfg_data_i),
    .entry_index_i  (entry_index_i),
    .entry_value_i  (entry_value_i),
    .search_value_i (search_value_i),
    .done_o         (done_o),
    .found_index_o  (found_index_o),
    .beyond_end_o   (beyond_end_o)
  );

endmodule

### hw/rtl/cdfls_ctrl.sv
// ----------------------------------------------------------------------------
// Search controller
// Sequences one load or one binary search query at a time.
// ----------------------------------------------------------------------------
module cdfls_ctrl import cdfls_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    start_i,
  input  logic    opcode_i,
  input  status_t status_i,
  output logic    busy_o,
  output cmd_t    cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    busy_o  = (state_q != ST_IDLE);
    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          if (opcode_e'(opcode_i) == OP_QUERY) begin
            cmd_o.launch = 1'b1;
            state_d      = ST_FIRST;
          end else begin
            cmd_o.load = 1'b1;
          end
        end
      end
      ST_FIRST: begin
        cmd_o.first = 1'b1;
        cmd_o.emit  = status_i.done;
        state_d     = status_i.done ? ST_IDLE : ST_PROBE;
      end
      ST_PROBE: begin
        cmd_o.probe = 1'b1;
        cmd_o.emit  = status_i.done;
        state_d     = status_i.done ? ST_IDLE : ST_PROBE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

### hw/rtl/cdfls_dpath.sv
// ----------------------------------------------------------------------------
// Search datapath
// Weight table memory, search window registers, probe compare and result.
// ----------------------------------------------------------------------------
module cdfls_dpath import cdfls_pkg::*; #(
  parameter int unsigned TABLE_DEPTH = DEF_TABLE_DEPTH,
  parameter int unsigned VALUE_BITS  = DEF_VALUE_BITS,
  localparam int unsigned ADDR_W     = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  cmd_t                   cmd_i,
  output status_t                status_o,
  input  logic                   cfg_we_i,
  input  logic [IDX_W-1:0]       cfg_data_i,
  input  logic [ENTRY_IDX_W-1:0] entry_index_i,
  input  logic [FIELD_VAL_W-1:0] entry_value_i,
  input  logic [FIELD_VAL_W-1:0] search_value_i,
  output logic                   done_o,
  output logic [IDX_W-1:0]       found_index_o,
  output logic                   beyond_end_o
);

  logic [VALUE_BITS-1:0] table_mem_q [TABLE_DEPTH];
  logic [VALUE_BITS-1:0] rd_a_q, rd_b_q, val_q;
  logic [IDX_W-1:0]      count_q, n_eff, n_q, low_q, high_q, mid_q;
  logic [IDX_W-1:0]      lo_nx, hi_nx, mid_nx, res_idx;
  logic [IDX_W:0]        win_sum;
  logic [ADDR_W-1:0]     addr_a, addr_b;
  logic                  hit, empty, above_prev, within_mid;
  logic                  done_q, beyond_q;
  logic [IDX_W-1:0]      found_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= COUNT_RESET;
    end else if (cfg_we_i) begin
      count_q <= cfg_data_i;
    end
  end

  always_comb begin
    if (count_q == '0) begin
      n_eff = IDX_W'(1);
    end else if (32'(count_q) > TABLE_DEPTH) begin
      n_eff = IDX_W'(TABLE_DEPTH);
    end else begin
      n_eff = count_q;
    end
  end

  assign above_prev = (rd_a_q < val_q);
  assign within_mid = (val_q <= rd_b_q);

  always_comb begin
    lo_nx = low_q;
    hi_nx = high_q;
    hit   = 1'b0;
    if (cmd_i.first) begin
      hit = (val_q <= rd_a_q);
    end else if (cmd_i.probe) begin
      hit = above_prev & within_mid;
      if (above_prev) begin
        lo_nx = mid_q + 1'b1;
      end else begin
        hi_nx = mid_q - 1'b1;
      end
    end
    empty   = (lo_nx > hi_nx);
    win_sum = {1'b0, lo_nx} + {1'b0, hi_nx};
    mid_nx  = IDX_W'(win_sum >> 1);
    if (hit) begin
      res_idx = cmd_i.first ? '0 : mid_q;
    end else begin
      res_idx = n_q;
    end
  end

  assign status_o.done = hit | empty;

  assign addr_b = ADDR_W'(mid_nx);
  assign addr_a = (cmd_i.first | cmd_i.probe) ? ADDR_W'(mid_nx - 1'b1) : '0;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load && (32'(entry_index_i) < TABLE_DEPTH)) begin
      table_mem_q[ADDR_W'(entry_index_i)] <= VALUE_BITS'(entry_value_i);
    end
    rd_a_q <= table_mem_q[addr_a];
    rd_b_q <= table_mem_q[addr_b];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.launch) begin
      val_q  <= VALUE_BITS'(search_value_i);
      n_q    <= n_eff;
      low_q  <= IDX_W'(1);
      high_q <= n_eff - 1'b1;
    end else if (cmd_i.first | cmd_i.probe) begin
      low_q  <= lo_nx;
      high_q <= hi_nx;
      mid_q  <= mid_nx;
    end
    if (cmd_i.emit) begin
      found_q  <= res_idx;
      beyond_q <= ~hit;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= cmd_i.emit;
    end
  end

  assign done_o        = done_q;
  assign found_index_o = found_q;
  assign beyond_end_o  = beyond_q;

endmodule

### hw/rtl/cdfls_checker.sv
// ----------------------------------------------------------------------------
// Port checker for the cumulative-weight search block
// Watches the top-level ports and is attached by a bind statement.
// ----------------------------------------------------------------------------
`include "cdf_lower_bound_search_top_assert.svh"

module cdfls_checker import cdfls_pkg::*; #(
  parameter int unsigned TABLE_DEPTH = DEF_TABLE_DEPTH
) (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   start_i,
  input logic                   busy_o,
  input logic                   opcode_i,
  input logic                   done_o,
  input logic [IDX_W-1:0]       found_index_o,
  input logic                   beyond_end_o
);

  logic load_beat, query_beat, index_ok;

  assign load_beat  = start_i & ~busy_o & (opcode_e'(opcode_i) == OP_LOAD);
  assign query_beat = start_i & ~busy_o & (opcode_e'(opcode_i) == OP_QUERY);
  assign index_ok   = (32'(found_index_o) <= TABLE_DEPTH) &&
                      (!beyond_end_o || found_index_o != '0);

  `CDFLS_ASSERT_NEXT(a_query_goes_busy, query_beat, busy_o, "query did not raise busy")
  `CDFLS_ASSERT_NEXT(a_load_no_result, load_beat, !done_o, "load produced a result")
  `CDFLS_ASSERT_NEXT(a_result_spacing, done_o, !done_o, "results closer than two cycles")
  `CDFLS_ASSERT_IMPL(a_index_range, done_o, index_ok, "result index out of range")

endmodule

bind cdf_lower_bound_search_top cdfls_checker #(
  .TABLE_DEPTH (TABLE_DEPTH)
) u_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .start_i       (start_i),
  .busy_o        (busy_o),
  .opcode_i      (opcode_i),
  .done_o        (done_o),
  .found_index_o (found_index_o),
  .beyond_end_o  (beyond_end_o)
);
